/* hw/rtl/sslsc_pkg.sv */
// Shared types, constants and the header CRC for the slot status log scanner.
// No dependencies; imported by every module of the block.
`default_nettype none

package sslsc_pkg;

  localparam logic [31:0] LOG_MAGIC  = 32'h5354_4C54;
  localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
  localparam logic [31:0] WORD_ONES  = 32'hFFFF_FFFF;
  localparam logic [7:0]  BYTE_ONES  = 8'hFF;

  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 120;
  localparam int INDEX_W    = 12;
  localparam int FREE_W     = 13;

  typedef struct packed {
    logic [31:0] crc;
    logic [7:0]  reserved;
    logic [7:0]  good;
    logic [7:0]  fails;
    logic [7:0]  slot;
    logic [31:0] seq;
    logic [31:0] magic;
  } record_t;

  typedef struct packed {
    logic valid;
    logic erased;
  } rec_flags_t;

  // Reflected CRC-32 over magic (LE), seq (LE), slot; bits taken LSB first.
  function automatic logic [31:0] header_crc(input logic [31:0] magic,
                                             input logic [31:0] seq,
                                             input logic [7:0]  slot);
    logic [71:0] msg;
    logic [31:0] crc;
    logic        fb;
    msg = {slot, seq, magic};
    crc = WORD_ONES;
    for (int i = 0; i < 72; i++) begin
      fb  = crc[0] ^ msg[i];
      crc = crc >> 1;
      if (fb) begin
        crc = crc ^ CRC_POLY;
      end
    end
    return crc ^ WORD_ONES;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/sslsc_rec_check.sv */
// Record classifier: magic + header CRC check and erased-record detect.
// Depends on sslsc_pkg.
`default_nettype none

module sslsc_rec_check
  import sslsc_pkg::*;
(
  input  record_t    rec,
  output rec_flags_t flags
);

  assign flags.valid = (rec.magic == LOG_MAGIC) &&
                       (header_crc(rec.magic, rec.seq, rec.slot) == rec.crc);

  assign flags.erased = (rec.magic == WORD_ONES) && (rec.seq == WORD_ONES) &&
                        (rec.slot == BYTE_ONES) && (rec.fails == BYTE_ONES) &&
                        (rec.good == BYTE_ONES) && (rec.reserved == BYTE_ONES) &&
                        (rec.crc == WORD_ONES);

endmodule

`default_nettype wire

/* hw/rtl/sslsc_tracker.sv */
// Scan state (best valid record, first erased record, count) and the
// summary result register. Depends on sslsc_pkg.
`default_nettype none

module sslsc_tracker
  import sslsc_pkg::*;
#(
  parameter int MAX_RECORDS = 4096
)(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  input  logic                  item_last,
  input  record_t               item_rec,
  input  rec_flags_t            item_flags,
  output logic                  item_take,
  output logic                  res_valid,
  input  logic                  res_ready,
  output logic [OUT_DATA_W-1:0] res_data
);

  localparam int CW = $clog2(MAX_RECORDS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_RECORDS);

  logic [CW-1:0] scanned_count, scanned_count_next;
  logic          best_valid_seen, best_valid_seen_next;
  logic [CW-1:0] best_position, best_position_next;
  logic [31:0]   best_sequence, best_sequence_next;
  logic [7:0]    best_slot_code, best_slot_code_next;
  logic [7:0]    best_failures, best_failures_next;
  logic [7:0]    best_good_mark, best_good_mark_next;
  logic          free_seen, free_seen_next;
  logic [CW-1:0] free_position, free_position_next;

  logic                  in_range;
  logic [CW+FREE_W-1:0]  best_pos_ext;
  logic [CW+FREE_W-1:0]  free_ext;
  logic [OUT_DATA_W-1:0] summary;

  assign item_take = item_valid && (!item_last || !res_valid || res_ready);
  assign in_range  = scanned_count < CNT_MAX;

  always_comb begin
    scanned_count_next   = scanned_count;
    best_valid_seen_next = best_valid_seen;
    best_position_next   = best_position;
    best_sequence_next   = best_sequence;
    best_slot_code_next  = best_slot_code;
    best_failures_next   = best_failures;
    best_good_mark_next  = best_good_mark;
    free_seen_next       = free_seen;
    free_position_next   = free_position;
    if (in_range) begin
      if (item_flags.erased && !free_seen) begin
        free_seen_next     = 1'b1;
        free_position_next = scanned_count;
      end
      if (item_flags.valid && (!best_valid_seen || item_rec.seq > best_sequence)) begin
        best_valid_seen_next = 1'b1;
        best_position_next   = scanned_count;
        best_sequence_next   = item_rec.seq;
        best_slot_code_next  = item_rec.slot;
        best_failures_next   = item_rec.fails;
        best_good_mark_next  = item_rec.good;
      end
      scanned_count_next = scanned_count + CW'(1);
    end
  end

  assign best_pos_ext = {{FREE_W{1'b0}}, best_position_next};
  assign free_ext     = free_seen_next ? {{FREE_W{1'b0}}, free_position_next}
                                       : {{FREE_W{1'b0}}, scanned_count_next};

  // fields from bit 0: found, best index, best seq, best slot, best fail count,
  // best good, good unknown, first free index, log full, next sequence
  always_comb begin
    summary = '0;
    summary[0]     = best_valid_seen_next;
    if (best_valid_seen_next) begin
      summary[12:1]  = best_pos_ext[INDEX_W-1:0];
      summary[44:13] = best_sequence_next;
      summary[52:45] = best_slot_code_next;
      summary[60:53] = best_failures_next;
      summary[68:61] = best_good_mark_next;
      summary[69]    = (best_good_mark_next == BYTE_ONES);
    end
    summary[82:70] = free_ext[FREE_W-1:0];
    summary[83]    = !free_seen_next;
    summary[115:84] = (best_valid_seen_next && free_seen_next) ?
                      best_sequence_next + 32'd1 : 32'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scanned_count   <= '0;
      best_valid_seen <= 1'b0;
      best_position   <= '0;
      best_sequence   <= '0;
      best_slot_code  <= '0;
      best_failures   <= '0;
      best_good_mark  <= '0;
      free_seen       <= 1'b0;
      free_position   <= '0;
      res_valid       <= 1'b0;
    end else begin
      if (item_take) begin
        if (item_last) begin
          scanned_count   <= '0;
          best_valid_seen <= 1'b0;
          best_position   <= '0;
          best_sequence   <= '0;
          best_slot_code  <= '0;
          best_failures   <= '0;
          best_good_mark  <= '0;
          free_seen       <= 1'b0;
          free_position   <= '0;
        end else begin
          scanned_count   <= scanned_count_next;
          best_valid_seen <= best_valid_seen_next;
          best_position   <= best_position_next;
          best_sequence   <= best_sequence_next;
          best_slot_code  <= best_slot_code_next;
          best_failures   <= best_failures_next;
          best_good_mark  <= best_good_mark_next;
          free_seen       <= free_seen_next;
          free_position   <= free_position_next;
        end
      end
      if (item_take && item_last) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take && item_last) begin
      res_data <= summary;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/slot_status_log_scanner.sv */
// Top level of the slot status log scanner: input register, record
// classifier and scan tracker. Depends on sslsc_pkg, sslsc_rec_check, sslsc_tracker.
//
//  port group | dir | per item
//  s_*        | in  | one 16-byte log record, s_tlast on the final record of a scan
//  m_*        | out | one scan summary per record that had s_tlast set
//
//  One record per cycle sustained, except while a final record waits on a stalled
//  summary; a record is held in the input register and a final record's summary
//  lands in the result register when it is taken; the CRC check and best/free compare run combinationally between them.
//  rst (synchronous) clears the scan state and both valid flags.
//  A stalled summary holds only a final record; other records keep flowing.
`default_nettype none

module slot_status_log_scanner
  import sslsc_pkg::*;
#(
  parameter int MAX_RECORDS = 4096
)(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // magic, seq, slot, fail count, good mark, reserved, crc
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // found, best index, best seq, best slot, best fail count, best good,
  // good unknown, first free index, log full, next sequence, zero pad
  output logic [OUT_DATA_W-1:0] m_tdata
);

  logic       hold_valid;
  logic       hold_last;
  record_t    hold_rec;
  rec_flags_t flags;
  logic       take;

  assign s_tready = !hold_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (s_tready) begin
      hold_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      hold_rec  <= record_t'(s_tdata);
      hold_last <= s_tlast;
    end
  end

  sslsc_rec_check u_check (
    .rec   (hold_rec),
    .flags (flags)
  );

  sslsc_tracker #(
    .MAX_RECORDS (MAX_RECORDS)
  ) u_tracker (
    .clk        (clk),
    .rst        (rst),
    .item_valid (hold_valid),
    .item_last  (hold_last),
    .item_rec   (hold_rec),
    .item_flags (flags),
    .item_take  (take),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready),
    .res_data   (m_tdata)
  );

endmodule

`default_nettype wire
